### src/msr_pkg.sv
// Shared types and constants for the multichannel scaler readout.
// Used by the front queue, the execute stage, the result queue and the top level.
package msr_pkg;

  // Signal index space and fixed field widths
  localparam int NUM_SIGNALS   = 32;
  localparam int SIG_W         = 5;
  localparam int WORD_W        = 32;
  localparam int ADDR_W        = 18;
  localparam int CHAN_OUT_W    = 13;
  localparam int SIGS_CFG_W    = 6;
  localparam int CHANS_CFG_W   = 14;
  localparam int CFG_DATA_W    = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int OP_W          = 2;
  // Wide enough for 31 * 65536 + 65536
  localparam int ADDR_CALC_W   = 23;

  // Queue depth between stages and in front of the result ports
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = 1;
  localparam int Q_CNT_W       = 2;

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_PRESET  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANS = 2'd2;

  // Configuration reset values
  localparam logic [SIGS_CFG_W-1:0]  CFG_SIGS_RST  = 6'd32;
  localparam logic [CHANS_CFG_W-1:0] CFG_CHANS_RST = 14'd8192;

  // Acquisition modes
  localparam logic MODE_MCS    = 1'b0;

  // Item class decided at the front
  typedef enum logic [1:0] {
    K_DATA,
    K_RESTART,
    K_PRESET,
    K_NOP
  } kind_t;

  // Classified command handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  word;
    logic [SIG_W-1:0]   preset_index;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [ADDR_W-1:0]     write_address;
    logic [WORD_W-1:0]     value;
    logic [SIG_W-1:0]      signal_index;
    logic [CHAN_OUT_W-1:0] channel_index;
    logic                  sweep_end;
    logic                  done_res;
    logic                  dropped;
  } res_t;

endpackage

### src/msr_front.sv
// Front stage of the scaler readout: accepts input items, decodes the op
// and holds classified commands in a short queue. Depends on msr_pkg.
module msr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       full,
  input  logic [msr_pkg::OP_W-1:0]   in_op,
  input  logic [msr_pkg::WORD_W-1:0] in_word,
  input  logic [msr_pkg::SIG_W-1:0]  in_preset_index,
  output logic                       cmd_valid,
  output msr_pkg::cmd_t              cmd,
  input  logic                       cmd_take
);
  import msr_pkg::*;

  cmd_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_ok;
  logic               pop_ok;
  cmd_t               cmd_in;

  // Classify the incoming op
  always_comb begin
    cmd_in.word         = in_word;
    cmd_in.preset_index = in_preset_index;
    unique case (in_op)
      OP_DATA:    cmd_in.kind = K_DATA;
      OP_RESTART: cmd_in.kind = K_RESTART;
      OP_PRESET:  cmd_in.kind = K_PRESET;
      default:    cmd_in.kind = K_NOP;
    endcase
  end

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push_ok   = in_push && !full;
  assign pop_ok    = cmd_take && cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified command
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### src/msr_back.sv
// Execute stage of the scaler readout: holds configuration, sweep position,
// per-signal totals and presets, and turns each command into one result.
// Depends on msr_pkg.
module msr_back #(
  parameter int MAX_CHANS = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [msr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           cmd_valid,
  input  msr_pkg::cmd_t                  cmd,
  output logic                           cmd_take,
  input  logic                           res_full,
  output logic                           res_push,
  output msr_pkg::res_t                  res
);
  import msr_pkg::*;

  localparam int CPW  = $clog2(MAX_CHANS + 1);
  localparam int CMPW = (CPW > CHANS_CFG_W) ? CPW : CHANS_CFG_W;

  // Configuration
  logic                   mode_r;
  logic [SIGS_CFG_W-1:0]  sigs_r;
  logic [CHANS_CFG_W-1:0] chans_r;

  // Acquisition state
  logic [SIG_W-1:0]  sig_r, sig_nxt;
  logic [CPW-1:0]    ch_r, ch_nxt;
  logic              hit_r, hit_nxt;
  logic              fin_r, fin_nxt;
  logic [WORD_W-1:0] tot_r [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] tot_vld_r;
  logic [WORD_W-1:0] pre_r [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] pre_vld_r;

  logic                  exec;
  logic                  tot_we;
  logic                  tot_clr;
  logic                  pre_we;
  logic [SIGS_CFG_W-1:0] s_eff;
  logic [CMPW-1:0]       chans_ext;
  logic [CMPW-1:0]       c_eff;
  logic [CMPW-1:0]       ch_ext;
  logic [CPW-1:0]        ch_inc;
  logic [CMPW-1:0]       ch_inc_ext;
  logic                  last_sig;
  logic [WORD_W-1:0]     tot_rd;
  logic [WORD_W-1:0]     pre_rd;
  logic [WORD_W-1:0]     sum;
  logic                  hit_now;
  logic                  hit_sweep;
  logic [ADDR_CALC_W-1:0] addr_full;

  assign exec     = cmd_valid && !res_full;
  assign cmd_take = exec;
  assign res_push = exec;

  // Clamp configured counts to their legal ranges
  always_comb begin
    if (sigs_r == '0) begin
      s_eff = SIGS_CFG_W'(1);
    end else if (sigs_r > SIGS_CFG_W'(NUM_SIGNALS)) begin
      s_eff = SIGS_CFG_W'(NUM_SIGNALS);
    end else begin
      s_eff = sigs_r;
    end
    chans_ext = CMPW'(chans_r);
    if (chans_r == '0) begin
      c_eff = CMPW'(1);
    end else if (chans_ext > CMPW'(MAX_CHANS)) begin
      c_eff = CMPW'(MAX_CHANS);
    end else begin
      c_eff = chans_ext;
    end
  end

  // Per-signal lookups and the running sum
  assign tot_rd     = tot_vld_r[sig_r] ? tot_r[sig_r] : '0;
  assign pre_rd     = pre_vld_r[sig_r] ? pre_r[sig_r] : '0;
  assign sum        = tot_rd + cmd.word;
  assign hit_now    = (pre_rd != '0) && (sum >= pre_rd);
  assign hit_sweep  = hit_r || hit_now;
  assign last_sig   = ({1'b0, sig_r} + SIGS_CFG_W'(1)) >= s_eff;
  assign ch_ext     = CMPW'(ch_r);
  assign ch_inc     = ch_r + CPW'(1);
  assign ch_inc_ext = CMPW'(ch_inc);
  assign addr_full  = ADDR_CALC_W'(sig_r) * ADDR_CALC_W'(MAX_CHANS) + ADDR_CALC_W'(ch_r);

  // Execute one command
  always_comb begin
    sig_nxt = sig_r;
    ch_nxt  = ch_r;
    hit_nxt = hit_r;
    fin_nxt = fin_r;
    tot_we  = 1'b0;
    tot_clr = 1'b0;
    pre_we  = 1'b0;
    res     = '0;
    unique case (cmd.kind)
      K_RESTART: begin
        sig_nxt = '0;
        ch_nxt  = '0;
        hit_nxt = 1'b0;
        fin_nxt = 1'b0;
        tot_clr = 1'b1;
      end
      K_PRESET: begin
        pre_we = 1'b1;
      end
      K_DATA: begin
        if (fin_r) begin
          res.dropped = 1'b1;
        end else if (mode_r == MODE_MCS) begin
          if (ch_ext >= c_eff) begin
            // Channel count lowered to or below the position: stop here
            fin_nxt     = 1'b1;
            res.dropped = 1'b1;
          end else begin
            res.write_address = addr_full[ADDR_W-1:0];
            res.value         = cmd.word;
            res.signal_index  = sig_r;
            res.channel_index = ch_ext[CHAN_OUT_W-1:0];
            if (last_sig) begin
              sig_nxt       = '0;
              ch_nxt        = ch_inc;
              res.sweep_end = 1'b1;
              if (ch_inc_ext >= c_eff) begin
                fin_nxt = 1'b1;
              end
            end else begin
              sig_nxt = sig_r + 1'b1;
            end
          end
        end else begin
          tot_we           = 1'b1;
          res.value        = sum;
          res.signal_index = sig_r;
          if (last_sig) begin
            res.sweep_end = 1'b1;
            if (hit_sweep) begin
              fin_nxt = 1'b1;
            end
            hit_nxt = 1'b0;
            sig_nxt = '0;
          end else begin
            hit_nxt = hit_sweep;
            sig_nxt = sig_r + 1'b1;
          end
        end
      end
      default: begin
        // unused op: no state change
      end
    endcase
    res.done_res = fin_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MCS;
      sigs_r  <= CFG_SIGS_RST;
      chans_r <= CFG_CHANS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_SIGS:  sigs_r  <= cfg_data[SIGS_CFG_W-1:0];
        CFG_CHANS: chans_r <= cfg_data[CHANS_CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  // Position, flags and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r     <= '0;
      ch_r      <= '0;
      hit_r     <= 1'b0;
      fin_r     <= 1'b0;
      tot_vld_r <= '0;
      pre_vld_r <= '0;
    end else if (exec) begin
      sig_r <= sig_nxt;
      ch_r  <= ch_nxt;
      hit_r <= hit_nxt;
      fin_r <= fin_nxt;
      if (tot_clr) begin
        tot_vld_r <= '0;
      end else if (tot_we) begin
        tot_vld_r[sig_r] <= 1'b1;
      end
      if (pre_we) begin
        pre_vld_r[cmd.preset_index] <= 1'b1;
      end
    end
  end

  // Totals and presets
  always_ff @(posedge clk) begin
    if (exec && tot_we) begin
      tot_r[sig_r] <= sum;
    end
    if (exec && pre_we) begin
      pre_r[cmd.preset_index] <= cmd.word;
    end
  end

endmodule

### src/msr_outq.sv
// Result queue of the scaler readout: holds finished results until the
// consumer pops them. Depends on msr_pkg.
module msr_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  msr_pkg::res_t res,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output msr_pkg::res_t head
);
  import msr_pkg::*;

  res_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_ok;
  logic               pop_ok;

  assign res_full = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = res_push && !res_full;
  assign pop_ok   = pop && !empty;
  assign head     = q_mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= res;
    end
  end

endmodule

### src/multichannel_scaler_readout_top.sv
// Multichannel scaler readout. Takes one item per cycle unless a queue is full: a
// scaler FIFO word, a restart or a preset load. In multichannel mode each word comes
// back with its buffer address (signal * MAX_CHANS + channel); in scaler mode it comes
// back as the signal's running 32-bit total. Every item gives exactly one result. The
// rate is set by the read-modify-write of one total in the execute stage; a word
// reaches the result ports through the registered front and result queues. Totals and
// presets sit in 32-entry register files with valid bits, so reset and restart take
// effect at once with no clearing pass. Configuration may be written only when idle.
// Depends on msr_pkg, msr_front, msr_back and msr_outq.
module multichannel_scaler_readout_top #(
  parameter int MAX_CHANS = 8192
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               full,
  input  logic [msr_pkg::OP_W-1:0]           in_op,
  input  logic [msr_pkg::WORD_W-1:0]         in_word,
  input  logic [msr_pkg::SIG_W-1:0]          in_preset_index,
  output logic                               empty,
  input  logic                               pop,
  output logic [msr_pkg::ADDR_W-1:0]         out_write_address,
  output logic [msr_pkg::WORD_W-1:0]         out_value,
  output logic [msr_pkg::SIG_W-1:0]          out_signal_index,
  output logic [msr_pkg::CHAN_OUT_W-1:0]     out_channel_index,
  output logic                               out_sweep_end,
  output logic                               out_done_res,
  output logic                               out_dropped,
  input  logic                               cfg_wr_en,
  input  logic [msr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import msr_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_full;
  logic res_push;
  res_t res;
  res_t head;

  // Accept and classify
  msr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .full            (full),
    .in_op           (in_op),
    .in_word         (in_word),
    .in_preset_index (in_preset_index),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take)
  );

  // Execute
  msr_back #(
    .MAX_CHANS (MAX_CHANS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Hold results for the consumer
  msr_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign out_write_address = head.write_address;
  assign out_value         = head.value;
  assign out_signal_index  = head.signal_index;
  assign out_channel_index = head.channel_index;
  assign out_sweep_end     = head.sweep_end;
  assign out_done_res      = head.done_res;
  assign out_dropped       = head.dropped;

endmodule
